// File: rtl/priority_process_queue_core_defines.svh
// Assertion shorthands used by the queue RTL.
// Each expects signals named clk and rst in the module that uses it.
`ifndef PRIORITY_PROCESS_QUEUE_CORE_DEFINES_SVH
`define PRIORITY_PROCESS_QUEUE_CORE_DEFINES_SVH

// Condition that holds on every cycle outside reset
`define PPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that holds in the same cycle as its cause
`define PPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that holds in the cycle after its cause
`define PPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppq_pkg.sv
package ppq_pkg;

  localparam int ID_W   = 5;
  localparam int PRIO_W = 8;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT      = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE_HEAD = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE_ID   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    entry_t            taken;
    logic              is_empty;
    entry_t            front;
    logic [FILL_W-1:0] fill;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_REM,
    S_FIN
  } seq_state_t;

endpackage

// File: rtl/ppq_mem.sv
module ppq_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ppq_pkg::entry_t          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ppq_pkg::entry_t          wr_data
);
  import ppq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/ppq_seq.sv
module ppq_seq #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppq_pkg::FUNC_W-1:0]    in_func,
  input  ppq_pkg::entry_t               in_ent,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ppq_pkg::res_t                 res,
  output logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  ppq_pkg::entry_t               rd_data,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr,
  output ppq_pkg::entry_t               wr_data
);
  import ppq_pkg::*;
  `include "priority_process_queue_core_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  seq_state_t        state, state_next;
  logic [AW-1:0]     k;
  logic [CW-1:0]     cnt;
  logic              found;
  logic              at_head;
  entry_t            head;
  entry_t            taken;
  entry_t            op_ent;
  logic [FUNC_W-1:0] op_func;
  logic [STAT_W-1:0] status;

  logic [AW-1:0]     last_idx;
  logic              rem_last;
  logic              hit;
  logic              place;

  assign last_idx = AW'(cnt - CW'(1));
  assign rem_last = (CW'(k) == (cnt - CW'(1)));
  assign hit      = !found && ((op_func == OP_REMOVE_HEAD) || (rd_data.id == op_ent.id));
  assign place    = (rd_data.prio >= op_ent.prio);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    idle       = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = k;
    wr_en      = 1'b0;
    wr_addr    = k;
    wr_data    = rd_data;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          priority if (in_func == OP_INSERT) begin
            rd_addr = last_idx;
            if (cnt == CW'(DEPTH)) begin
              state_next = S_FIN;
            end else if (cnt == '0) begin
              state_next = S_INS_LAST;
            end else begin
              state_next = S_INS;
            end
          end else if ((in_func == OP_REMOVE_HEAD) || (in_func == OP_REMOVE_ID)) begin
            rd_addr    = '0;
            state_next = (cnt == '0) ? S_FIN : S_REM;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      // Walk down from the tail, shifting each lower-priority entry up one slot
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k + AW'(1));
        wr_data = place ? op_ent : rd_data;
        rd_addr = AW'(k - AW'(1));
        if (place) begin
          state_next = S_FIN;
        end else if (k == '0) begin
          state_next = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = op_ent;
        state_next = S_FIN;
      end
      // Walk up from the head, closing the gap behind the removed entry
      S_REM: begin
        wr_en   = found;
        wr_addr = AW'(k - AW'(1));
        wr_data = rd_data;
        rd_addr = AW'(k + AW'(1));
        if (rem_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      priority if (state == S_INS_LAST || (state == S_INS && place)) begin
        cnt <= cnt + CW'(1);
      end else if (state == S_REM && rem_last && (found || hit)) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Walk datapath: index, captured operation, removed entry, cached head
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_func <= in_func;
        op_ent  <= in_ent;
        taken   <= '0;
        found   <= 1'b0;
        at_head <= 1'b0;
        k       <= (in_func == OP_INSERT) ? last_idx : '0;
        priority if (in_func == OP_INSERT) begin
          status <= (cnt == CW'(DEPTH)) ? STAT_FULL : STAT_DONE;
        end else if ((in_func == OP_REMOVE_HEAD) || (in_func == OP_REMOVE_ID)) begin
          status <= (cnt == '0) ? STAT_MISS : STAT_DONE;
        end else begin
          status <= STAT_DONE;
        end
      end
      S_INS: begin
        k <= AW'(k - AW'(1));
      end
      S_INS_LAST: begin
        head <= op_ent;
      end
      S_REM: begin
        k <= AW'(k + AW'(1));
        if (hit) begin
          found   <= 1'b1;
          taken   <= rd_data;
          at_head <= (k == '0);
        end
        // Old second entry becomes the head once the head is taken
        if (found && at_head && k == AW'(1)) begin
          head <= rd_data;
        end
        if (rem_last && !(found || hit)) begin
          status <= STAT_MISS;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Result as it stands after the operation
  always_comb begin
    res.status   = status;
    res.taken    = taken;
    res.is_empty = (cnt == '0);
    res.front    = (cnt == '0) ? entry_t'('0) : head;
    res.fill     = FILL_W'(cnt);
  end

  `PPQ_ASSERT_ALWAYS(a_cnt_bound, cnt <= CW'(DEPTH), "entry count above depth")
  `PPQ_ASSERT_IMP(a_full_only_at_depth, state == S_FIN && status == STAT_FULL,
    cnt == CW'(DEPTH), "full reported below depth")
  `PPQ_ASSERT_NEXT(a_remove_drops_one, state == S_REM && rem_last && (found || hit),
    cnt == $past(cnt) - CW'(1), "removal did not drop the count by one")
  `PPQ_ASSERT_IMP(a_write_in_range, wr_en, CW'(wr_addr) <= cnt,
    "write beyond the end of the queue")

endmodule

// File: rtl/priority_process_queue_core.sv
// Sorted priority queue of process identifiers, highest priority first,
// equal priorities kept in arrival order.
// Input channel s_*: one operation per transaction (insert, remove head,
// remove by identifier). Output channel m_*: one result per operation,
// giving status, the removed entry, and head, empty flag and count as they
// stand after the operation.
// Entries live in a single memory with a registered read port; an insert or
// remove walks it one entry a cycle, reading one slot and writing its
// neighbour. A remove walks every entry, an insert only those behind the new
// one, and a refused insert, a remove from an empty queue or an ignored
// operation code goes straight to the result. The next operation is accepted
// from the cycle after the previous result is loaded, so operations are taken
// one at a time.
// Reset empties the queue at once; no clearing pass is needed.
// If the receiver stalls, the result holds in the output register and a
// further finished result waits in the sequencer, which then takes no
// new transaction.
module priority_process_queue_core #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // proc_id[4:0], prio[12:5], zero fill
  input  logic [1:0]  s_tuser,  // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // taken_id[4:0], taken_prio[12:5], is_empty[13],
                                // front_id[18:14], front_prio[26:19], fill[32:27],
                                // zero fill
  output logic [1:0]  m_tuser   // status[1:0]
);
  import ppq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          start;
  logic          idle;
  entry_t        in_ent;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign s_tready    = idle;
  assign start       = s_tvalid && s_tready;
  assign in_ent.id   = s_tdata[4:0];
  assign in_ent.prio = s_tdata[12:5];
  assign res_ready   = !m_tvalid || m_tready;

  ppq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ppq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_func   (s_tuser),
    .in_ent    (in_ent),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= {7'd0, res.fill, res.front.prio, res.front.id, res.is_empty,
                  res.taken.prio, res.taken.id};
    end
  end

endmodule

// File: sim/priority_process_queue_core_tb.sv
module priority_process_queue_core_tb;
  import ppq_pkg::*;

  localparam int QDEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  // Operation code that the block must ignore
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  // Which way the random mix pushes the queue depth
  typedef enum int {LEAN_GROW, LEAN_EVEN, LEAN_SHRINK} lean_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // proc_id[4:0], prio[12:5], zero fill
  logic [1:0]  s_tuser;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // taken_id[4:0], taken_prio[12:5], is_empty[13],
                          // front_id[18:14], front_prio[26:19], fill[32:27], zero fill
  logic [1:0]  m_tuser;   // status[1:0]

  // Shadow of the sorted queue and the reports it owes the block
  entry_t ordered_entries[$];
  res_t   queue_reports[$];

  bit no_gaps;
  int cycle_count;
  int mismatch_count;
  int results_checked;
  int n_insert, n_head, n_by_id, n_unused, n_refused, n_missed, peak_fill;
  res_t got_report, want_report;

  priority_process_queue_core #(.DEPTH(QDEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the shadow queue and return the report it yields
  function automatic res_t apply_queue_op(input logic [FUNC_W-1:0] op,
                                          input logic [ID_W-1:0] pid,
                                          input logic [PRIO_W-1:0] pr);
    res_t   r;
    entry_t e;
    int     pos;
    int     k;
    r = '0;
    r.status = STAT_DONE;
    case (op)
      OP_INSERT: begin
        if (ordered_entries.size() >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // land behind every entry of equal or higher priority
          pos = 0;
          while (pos < ordered_entries.size() && ordered_entries[pos].prio >= pr) pos++;
          e.id = pid;
          e.prio = pr;
          ordered_entries.insert(pos, e);
        end
      end
      OP_REMOVE_HEAD: begin
        if (ordered_entries.size() == 0) r.status = STAT_MISS;
        else r.taken = ordered_entries.pop_front();
      end
      OP_REMOVE_ID: begin
        pos = -1;
        for (k = 0; k < ordered_entries.size() && pos < 0; k++) begin
          if (ordered_entries[k].id == pid) pos = k;
        end
        if (pos < 0) begin
          r.status = STAT_MISS;
        end else begin
          r.taken = ordered_entries[pos];
          ordered_entries.delete(pos);
        end
      end
      default: ;
    endcase
    r.is_empty = (ordered_entries.size() == 0);
    if (ordered_entries.size() != 0) r.front = ordered_entries[0];
    r.fill = FILL_W'(ordered_entries.size());
    return r;
  endfunction

  // Render one report for a mismatch message
  function automatic string show_report(input res_t r);
    return $sformatf("st=%0d taken=%0d/%0d empty=%0b front=%0d/%0d fill=%0d",
                     r.status, r.taken.id, r.taken.prio, r.is_empty,
                     r.front.id, r.front.prio, r.fill);
  endfunction

  // Half the time pick a priority from a small set so that ties are common
  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] pr;
    pr = PRIO_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: pr = 8'd0;
        1: pr = 8'd1;
        2: pr = 8'd127;
        3: pr = 8'd128;
        4: pr = 8'd254;
        default: pr = 8'd255;
      endcase
    end
    return pr;
  endfunction

  // Draw a random process identifier
  function automatic logic [ID_W-1:0] pick_id();
    return ID_W'($urandom_range(0, 31));
  endfunction

  // Offer one operation, hold it until taken, then record what it owes
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] pid,
                         input logic [PRIO_W-1:0] pr);
    res_t r;
    s_tvalid = 1'b0;
    while (!no_gaps && $urandom_range(0, 99) < 33) @(negedge clk);
    s_tuser = op;
    s_tdata = {3'b000, pr, pid};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_queue_op(op, pid, pr);
    queue_reports.push_back(r);
    case (op)
      OP_INSERT:      n_insert++;
      OP_REMOVE_HEAD: n_head++;
      OP_REMOVE_ID:   n_by_id++;
      default:        n_unused++;
    endcase
    if (r.status == STAT_FULL) n_refused++;
    if (r.status == STAT_MISS) n_missed++;
    if (ordered_entries.size() > peak_fill) peak_fill = ordered_entries.size();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Draw one operation; removals by identifier mostly aim at a held entry
  task automatic random_op(input lean_t lean);
    int                ins_pct;
    int                roll;
    logic [FUNC_W-1:0] op;
    logic [ID_W-1:0]   pid;
    logic [PRIO_W-1:0] pr;
    ins_pct = (lean == LEAN_GROW) ? 70 : (lean == LEAN_EVEN) ? 48 : 25;
    roll = $urandom_range(0, 99);
    pid = pick_id();
    pr = pick_prio();
    if (roll < 3) begin
      op = OP_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      op = OP_INSERT;
    end else if (roll < 3 + ins_pct + (97 - ins_pct) / 2) begin
      op = OP_REMOVE_HEAD;
    end else begin
      op = OP_REMOVE_ID;
      if (ordered_entries.size() != 0 && $urandom_range(0, 9) < 8)
        pid = ordered_entries[$urandom_range(0, ordered_entries.size() - 1)].id;
    end
    send_op(op, pid, pr);
  endtask

  // Empty-queue cases, field extremes, ties, duplicates and the ignored code
  task automatic test_directed();
    send_op(OP_REMOVE_HEAD, 5'd0, 8'd0);
    send_op(OP_REMOVE_ID, 5'd5, 8'd0);
    send_op(OP_UNUSED, 5'd31, 8'd255);
    send_op(OP_INSERT, 5'd31, 8'd0);
    send_op(OP_INSERT, 5'd0, 8'd255);
    send_op(OP_INSERT, 5'd17, 8'd128);
    send_op(OP_INSERT, 5'd9, 8'd128);
    send_op(OP_INSERT, 5'd17, 8'd200);
    send_op(OP_UNUSED, 5'd12, 8'd77);
    send_op(OP_REMOVE_ID, 5'd17, 8'd0);
    send_op(OP_REMOVE_ID, 5'd3, 8'd255);
    send_op(OP_REMOVE_HEAD, 5'd31, 8'd255);
    send_op(OP_REMOVE_ID, 5'd31, 8'd0);
    send_op(OP_INSERT, 5'd22, 8'd128);
    send_op(OP_REMOVE_HEAD, 5'd0, 8'd0);
    send_op(OP_REMOVE_HEAD, 5'd0, 8'd0);
    send_op(OP_REMOVE_HEAD, 5'd0, 8'd0);
    send_op(OP_REMOVE_HEAD, 5'd0, 8'd0);
    send_op(OP_INSERT, 5'd31, 8'd255);
    send_op(OP_REMOVE_ID, 5'd31, 8'hAA);
  endtask

  // Fill to capacity, knock on the full queue, then drain past empty
  task automatic test_fill_to_capacity();
    logic [ID_W-1:0] pid;
    while (ordered_entries.size() < QDEPTH) begin
      send_op(OP_INSERT, pick_id(), pick_prio());
    end
    repeat (3) send_op(OP_INSERT, pick_id(), pick_prio());
    pid = ordered_entries[$urandom_range(0, QDEPTH - 1)].id;
    send_op(OP_REMOVE_ID, pid, pick_prio());
    send_op(OP_INSERT, pick_id(), pick_prio());
    send_op(OP_INSERT, pick_id(), pick_prio());
    while (ordered_entries.size() != 0) begin
      send_op(OP_REMOVE_HEAD, pick_id(), pick_prio());
    end
    send_op(OP_REMOVE_HEAD, pick_id(), pick_prio());
  endtask

  // Random mix, swinging between growing, steady and shrinking the queue
  task automatic test_random_mix(input int n_items);
    int    i;
    lean_t lean;
    lean = LEAN_GROW;
    for (i = 0; i < n_items; i++) begin
      if (i % 50 == 0) lean = lean_t'($urandom_range(0, 2));
      random_op(lean);
    end
  endtask

  // Same mix with both sides ready on every cycle
  task automatic test_back_to_back(input int n_items);
    no_gaps = 1'b1;
    test_random_mix(n_items);
    no_gaps = 1'b0;
  endtask

  // Result receiver: stall at random unless the stretch runs without gaps
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = (rst == 1'b0) && (no_gaps || $urandom_range(0, 99) >= 33);
    end
  end

  // Compare each result with the oldest report owed
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_report.status     = m_tuser;
      got_report.taken.id   = m_tdata[4:0];
      got_report.taken.prio = m_tdata[12:5];
      got_report.is_empty   = m_tdata[13];
      got_report.front.id   = m_tdata[18:14];
      got_report.front.prio = m_tdata[26:19];
      got_report.fill       = m_tdata[32:27];
      results_checked++;
      if (queue_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d arrived with no operation pending", results_checked);
      end else begin
        want_report = queue_reports.pop_front();
        if (got_report.status !== want_report.status ||
            got_report.taken.id !== want_report.taken.id ||
            got_report.taken.prio !== want_report.taken.prio ||
            got_report.is_empty !== want_report.is_empty ||
            got_report.front.id !== want_report.front.id ||
            got_report.front.prio !== want_report.front.prio ||
            got_report.fill !== want_report.fill) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: expected %s, got %s", results_checked,
                     show_report(want_report), show_report(got_report));
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports still owed", cycle_count,
             queue_reports.size());
    $display("priority_process_queue_core_tb: done, errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_to_capacity();
    test_random_mix(420);
    test_back_to_back(150);
    test_random_mix(400);

    // hold until every owed report has come back, then let the block settle
    while (queue_reports.size() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);

    $display("ran %0d inserts, %0d head removals, %0d removals by id, %0d ignored codes",
             n_insert, n_head, n_by_id, n_unused);
    $display("%0d results checked: %0d refused as full, %0d misses, peak fill %0d",
             results_checked, n_refused, n_missed, peak_fill);
    if (mismatch_count == 0) begin
      $display("priority_process_queue_core_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("priority_process_queue_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: priority_process_queue_core.f
+incdir+rtl
rtl/ppq_pkg.sv
rtl/ppq_mem.sv
rtl/ppq_seq.sv
rtl/priority_process_queue_core.sv
sim/priority_process_queue_core_tb.sv
